### hw/rtl/zort_pkg.sv
// Shared types and constants for the zone ownership reference-count table.
package zort_pkg;

  localparam int ENTRIES = 64;
  localparam int ZONES   = 64;
  localparam int IDX_W   = 6;
  localparam int ZONE_W  = 6;
  localparam int MASK_W  = 64;
  localparam int CNT_W   = 16;
  localparam int OWN_W   = 7;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [MASK_W-1:0] ZONE_BITS =
    (ZONES >= MASK_W) ? '1 : ((MASK_W'(1) << ZONES) - MASK_W'(1));

  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_UNREGISTER = 2'd1;
  localparam logic [1:0] OP_RELEASE    = 2'd2;
  localparam logic [1:0] OP_CLEAR      = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [IDX_W-1:0]  string_index;
    logic [ZONE_W-1:0] zone;
    logic [MASK_W-1:0] zone_mask;
  } in_item_t;

  typedef struct packed {
    logic             freed_valid;
    logic [IDX_W-1:0] freed_index;
    logic [1:0]       status;
    logic             any_owned;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_REG,
    CMD_UNREG,
    CMD_REL,
    CMD_CLR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [ZONE_W-1:0] zone;
    logic [MASK_W-1:0] rel;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

### hw/rtl/zort_front.sv
// Front end: accept input transactions and classify them into commands.
module zort_front
  import zort_pkg::*;
(
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic addr_ok;
  logic zone_ok;
  logic [MASK_W-1:0] rel;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    addr_ok = (in_data.string_index != '0) &&
              ({1'b0, in_data.string_index} < (IDX_W + 1)'(ENTRIES));
    zone_ok = {1'b0, in_data.zone} < (ZONE_W + 1)'(ZONES);
    rel     = in_data.zone_mask & ZONE_BITS & ~MASK_W'(1);

    q_cmd.idx  = in_data.string_index;
    q_cmd.zone = in_data.zone;
    q_cmd.rel  = rel;
    unique case (in_data.op)
      OP_REGISTER:   q_cmd.kind = (addr_ok && zone_ok) ? CMD_REG : CMD_NOP;
      OP_UNREGISTER: q_cmd.kind = addr_ok ? CMD_UNREG : CMD_NOP;
      OP_RELEASE:    q_cmd.kind = (rel != '0) ? CMD_REL : CMD_NOP;
      OP_CLEAR:      q_cmd.kind = CMD_CLR;
    endcase
  end

endmodule

### hw/rtl/zort_queue.sv
// Short command queue between the front end and the execution engine.
module zort_queue
  import zort_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign head       = slot_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/zort_back.sv
// Execution engine: table memories, read-modify-write, release walk and result drain.
module zort_back
  import zort_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  q_stat_t   q_stat,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_WALK,
    S_DRAIN
  } state_t;

  logic [MASK_W-1:0] mask_mem [ENTRIES];
  logic [CNT_W-1:0]  cnt_mem  [ENTRIES];

  state_t            state_r,    state_nxt;
  cmd_t              cmd_r,      cmd_nxt;
  logic [IDX_W-1:0]  proc_idx_r, proc_idx_nxt;
  logic [IDX_W-1:0]  scan_r,     scan_nxt;
  logic [OWN_W-1:0]  owned_r,    owned_nxt;
  logic [OWN_W-1:0]  left_r,     left_nxt;
  logic [ENTRIES-1:0] freed_r,   freed_nxt;
  logic [ENTRIES-1:0] vld_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [MASK_W-1:0] mask_rd_r;
  logic [CNT_W-1:0]  cnt_rd_r;
  logic              ent_vld_r;

  logic [MASK_W-1:0] eff_mask;
  logic [CNT_W-1:0]  eff_cnt;
  logic              out_free;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  wr_addr;
  logic [MASK_W-1:0] wr_mask;
  logic [CNT_W-1:0]  wr_cnt;
  logic              clr;
  logic              emit;
  out_item_t         res;
  logic              zone0;
  logic [MASK_W-1:0] walk_mask;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign eff_mask  = ent_vld_r ? mask_rd_r : '0;
  assign eff_cnt   = ent_vld_r ? cnt_rd_r : '0;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    proc_idx_nxt = proc_idx_r;
    scan_nxt     = scan_r;
    owned_nxt    = owned_r;
    left_nxt     = left_r;
    freed_nxt    = freed_r;
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = head.idx;
    mem_we       = 1'b0;
    wr_addr      = cmd_r.idx;
    wr_mask      = eff_mask;
    wr_cnt       = eff_cnt;
    clr          = 1'b0;
    emit         = 1'b0;
    res          = '0;
    zone0        = (cmd_r.zone == '0);
    walk_mask    = eff_mask & ~cmd_r.rel;

    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          unique case (head.kind) inside
            CMD_NOP: begin
              if (out_free) begin
                q_pop         = 1'b1;
                emit          = 1'b1;
                res.status    = ST_OK;
                res.any_owned = (owned_r != '0);
                res.last      = 1'b1;
              end
            end
            CMD_CLR: begin
              if (out_free) begin
                q_pop     = 1'b1;
                clr       = 1'b1;
                owned_nxt = '0;
                emit      = 1'b1;
                res.last  = 1'b1;
              end
            end
            CMD_REG, CMD_UNREG: begin
              q_pop     = 1'b1;
              cmd_nxt   = head;
              rd_en     = 1'b1;
              state_nxt = S_RMW;
            end
            CMD_REL: begin
              q_pop        = 1'b1;
              cmd_nxt      = head;
              rd_en        = 1'b1;
              rd_addr      = IDX_W'(1);
              proc_idx_nxt = IDX_W'(1);
              freed_nxt    = '0;
              left_nxt     = '0;
              state_nxt    = S_WALK;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end

      S_RMW: begin
        if (out_free) begin
          emit      = 1'b1;
          res.last  = 1'b1;
          state_nxt = S_IDLE;
          if (cmd_r.kind == CMD_REG) begin
            if (zone0 && eff_cnt == COUNT_MAX) begin
              res.status = ST_OVERFLOW;
            end else begin
              mem_we  = 1'b1;
              wr_cnt  = eff_cnt + CNT_W'(zone0);
              wr_mask = eff_mask | (MASK_W'(1) << cmd_r.zone);
              if (eff_mask == '0) begin
                owned_nxt = owned_r + 1'b1;
              end
            end
          end else begin
            if (eff_cnt == '0) begin
              res.status = ST_UNDERFLOW;
            end else begin
              mem_we  = 1'b1;
              wr_cnt  = eff_cnt - 1'b1;
              wr_mask = (wr_cnt == '0) ? (eff_mask & ~MASK_W'(1)) : eff_mask;
              if (wr_mask == '0) begin
                res.freed_valid = 1'b1;
                res.freed_index = cmd_r.idx;
                if (eff_mask != '0 && owned_r != '0) begin
                  owned_nxt = owned_r - 1'b1;
                end
              end
            end
          end
          res.any_owned = (owned_nxt != '0);
        end
      end

      S_WALK: begin
        // Retire the entry read last cycle, fetch the next one.
        wr_addr = proc_idx_r;
        wr_mask = walk_mask;
        if ((eff_mask & cmd_r.rel) != '0) begin
          mem_we = 1'b1;
          if (walk_mask == '0) begin
            freed_nxt[proc_idx_r] = 1'b1;
            left_nxt              = left_r + 1'b1;
            if (owned_r != '0) begin
              owned_nxt = owned_r - 1'b1;
            end
          end
        end
        if (proc_idx_r != LAST_IDX) begin
          rd_en        = 1'b1;
          rd_addr      = proc_idx_r + 1'b1;
          proc_idx_nxt = proc_idx_r + 1'b1;
        end else begin
          scan_nxt  = IDX_W'(1);
          state_nxt = S_DRAIN;
        end
      end

      S_DRAIN: begin
        if (left_r == '0) begin
          if (out_free) begin
            emit          = 1'b1;
            res.any_owned = (owned_r != '0);
            res.last      = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (freed_r[scan_r]) begin
          if (out_free) begin
            emit            = 1'b1;
            res.freed_valid = 1'b1;
            res.freed_index = scan_r;
            res.any_owned   = (owned_r != '0);
            res.last        = (left_r == OWN_W'(1));
            left_nxt        = left_r - 1'b1;
            scan_nxt        = scan_r + 1'b1;
            if (left_r == OWN_W'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mask_mem[wr_addr] <= wr_mask;
      cnt_mem[wr_addr]  <= wr_cnt;
    end
    if (rd_en) begin
      mask_rd_r <= mask_mem[rd_addr];
      cnt_rd_r  <= cnt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      owned_r     <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      owned_r    <= owned_nxt;
      left_r     <= left_nxt;
      cmd_r      <= cmd_nxt;
      proc_idx_r <= proc_idx_nxt;
      scan_r     <= scan_nxt;
      freed_r    <= freed_nxt;
      if (rd_en) begin
        ent_vld_r <= vld_r[rd_addr];
      end
      if (clr) begin
        vld_r <= '0;
      end else if (mem_we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/zone_ownership_refcount_table.sv
// Zone ownership table: owner masks per entry, zone-0 reference counts, release walk.
// Register and unregister: memory read, then modify and write once the result channel is free.
// Query and clear: handled from idle; result appears the cycle after leaving the queue.
// Release: a walk over table entries 1 to ENTRIES-1, then a drain of the freed entries.
// Reset is synchronous: per-entry valid flops clear at once, so no clearing pass runs.
module zone_ownership_refcount_table
  import zort_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Front to queue: classified command per accepted transaction.
  logic    q_push;
  cmd_t    q_cmd;
  // Queue to back: head command and fill status.
  logic    q_pop;
  cmd_t    q_head;
  q_stat_t q_stat;

  // Classify: turn out-of-range requests into no-op commands up front; the
  // engine answers each with a plain status result and no table work.
  zort_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Decouple: hold up to two commands so the front keeps accepting while
  // the engine walks or waits on the result channel.
  zort_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // Execute: table memories with one read and one write port, release walk
  // collects freed entries in a bitmap and drains them afterwards so each
  // result carries the final ownership flag.
  zort_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !q_stat.empty)
    else $error("accepted transaction missing from queue");

  a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.freed_valid) |-> out_data.last)
    else $error("non-freed result not marked last");

  a_freed_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.freed_valid) |->
      (out_data.status == ST_OK && out_data.freed_index != '0))
    else $error("freed result with bad status or entry zero");

endmodule

### verif/tb_top.sv
// Self-checking testbench for the zone ownership reference-count table.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import zort_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_OPS  = 225;
  localparam int HOLD_CYCLES = 400;
  // Drain allowance: a release walks every entry but entry zero and then drains its freed events.
  localparam int DRAIN_CYCLES = 300;
  // Worst case is every transaction a release freeing all entries under heavy
  // stalls; keep a wide margin above it.
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  zone_ownership_refcount_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the table that the predictor keeps in step with the block.
  logic [MASK_W-1:0] zone_owners [ENTRIES];
  logic [CNT_W-1:0]  zone0_refs  [ENTRIES];
  int                owned_entries;

  in_item_t  pending_ops [$];      // transactions not yet put on the input port
  out_item_t expected_results [$]; // predicted results, oldest first

  int accepted_cnt = 0;
  int total_items  = 0;
  int hold_at      = 0;
  int fail_cnt     = 0;
  int cycle_cnt    = 0;

  // Zero the shadow table: used at reset and on a clear transaction.
  function automatic void wipe_table();
    for (int i = 0; i < ENTRIES; i++) begin
      zone_owners[i] = '0;
      zone0_refs[i]  = '0;
    end
    owned_entries = 0;
  endfunction

  function automatic in_item_t make_op(logic [1:0] op, int idx, int zone,
                                       logic [MASK_W-1:0] mask);
    in_item_t it;
    it.op           = op;
    it.string_index = IDX_W'(idx);
    it.zone         = ZONE_W'(zone);
    it.zone_mask    = mask;
    return it;
  endfunction

  // Work out the results of one accepted transaction and queue them.
  function automatic void predict_results(in_item_t it);
    out_item_t         r;
    logic [IDX_W-1:0]  idx;
    logic [MASK_W-1:0] rel;
    logic [MASK_W-1:0] prev;
    logic              addr_ok;
    int                freed [$];

    r         = '0;
    r.status  = ST_OK;
    r.last    = 1'b1;
    idx       = it.string_index;
    addr_ok   = (idx != '0) && (int'(idx) < ENTRIES);

    case (it.op)
      OP_REGISTER: begin
        if (addr_ok && int'(it.zone) < ZONES) begin
          if (it.zone == '0 && zone0_refs[idx] == COUNT_MAX) begin
            r.status = ST_OVERFLOW;
          end else begin
            if (it.zone == '0) zone0_refs[idx] = zone0_refs[idx] + 1'b1;
            if (zone_owners[idx] == '0) owned_entries++;
            zone_owners[idx][it.zone] = 1'b1;
          end
        end
      end
      OP_UNREGISTER: begin
        if (addr_ok) begin
          if (zone0_refs[idx] == '0) begin
            r.status = ST_UNDERFLOW;
          end else begin
            prev = zone_owners[idx];
            zone0_refs[idx] = zone0_refs[idx] - 1'b1;
            if (zone0_refs[idx] == '0) zone_owners[idx][0] = 1'b0;
            if (zone_owners[idx] == '0) begin
              r.freed_valid = 1'b1;
              r.freed_index = idx;
              if (prev != '0 && owned_entries > 0) owned_entries--;
            end
          end
        end
      end
      OP_RELEASE: begin
        // Zone 0 is never released; bits beyond the zone range drop out.
        rel    = it.zone_mask & ZONE_BITS;
        rel[0] = 1'b0;
        if (rel != '0) begin
          for (int i = 1; i < ENTRIES; i++) begin
            prev = zone_owners[i];
            if ((prev & rel) != '0) begin
              zone_owners[i] = prev & ~rel;
              if (zone_owners[i] == '0) begin
                if (owned_entries > 0) owned_entries--;
                freed.push_back(i);
              end
            end
          end
        end
        if (freed.size() != 0) begin
          for (int k = 0; k < freed.size(); k++) begin
            r             = '0;
            r.freed_valid = 1'b1;
            r.freed_index = IDX_W'(freed[k]);
            r.status      = ST_OK;
            r.any_owned   = (owned_entries != 0);
            r.last        = (k == freed.size() - 1);
            expected_results.push_back(r);
          end
          return;
        end
      end
      OP_CLEAR: begin
        wipe_table();
      end
      default: begin
      end
    endcase
    r.any_owned = (owned_entries != 0);
    expected_results.push_back(r);
  endfunction

  task automatic note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Stimulus: directed corner cases, then random traffic.
  initial begin
    in_item_t it;
    int       sel;
    int       pick;

    wipe_table();

    // Empty-table query, underflow, and entry zero ignored for both ops.
    pending_ops.push_back(make_op(OP_RELEASE, 0, 0, '0));
    pending_ops.push_back(make_op(OP_UNREGISTER, 5, 0, '0));
    pending_ops.push_back(make_op(OP_REGISTER, 0, 3, '0));
    pending_ops.push_back(make_op(OP_UNREGISTER, 0, 0, '0));
    // Top entry and top zone.
    pending_ops.push_back(make_op(OP_REGISTER, 63, 63, '0));
    pending_ops.push_back(make_op(OP_REGISTER, 1, 0, '0));
    pending_ops.push_back(make_op(OP_REGISTER, 1, 0, '0));
    pending_ops.push_back(make_op(OP_REGISTER, 1, 5, '0));
    pending_ops.push_back(make_op(OP_REGISTER, 2, 1, '0));
    // Mask with only zone 0 acts as a query; then strip zone 5 without freeing.
    pending_ops.push_back(make_op(OP_RELEASE, 0, 0, 64'h1));
    pending_ops.push_back(make_op(OP_RELEASE, 0, 0, 64'h20));
    // Count down to zero frees the entry; one more underflows.
    pending_ops.push_back(make_op(OP_UNREGISTER, 1, 0, '0));
    pending_ops.push_back(make_op(OP_UNREGISTER, 1, 0, '0));
    pending_ops.push_back(make_op(OP_UNREGISTER, 1, 0, '0));
    pending_ops.push_back(make_op(OP_REGISTER, 3, 0, '0));
    pending_ops.push_back(make_op(OP_REGISTER, 3, 63, '0));
    // Full mask frees entries 2 and 63, entry 3 keeps its zone-0 owner.
    pending_ops.push_back(make_op(OP_RELEASE, 0, 0, '1));
    pending_ops.push_back(make_op(OP_UNREGISTER, 3, 0, '0));
    pending_ops.push_back(make_op(OP_REGISTER, 10, 7, '0));
    pending_ops.push_back(make_op(OP_REGISTER, 11, 7, '0));
    pending_ops.push_back(make_op(OP_REGISTER, 12, 7, '0));
    pending_ops.push_back(make_op(OP_REGISTER, 12, 8, '0));
    pending_ops.push_back(make_op(OP_RELEASE, 0, 0, 64'h80));
    pending_ops.push_back(make_op(OP_REGISTER, 62, 40, '0));
    pending_ops.push_back(make_op(OP_CLEAR, 0, 0, '0));

    // Long receiver hold-off lands early in the random traffic.
    hold_at = pending_ops.size() + 40;

    // Random traffic: mostly a small pool of entries and zones, so owners
    // pile up and releases free several entries at once.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      it              = '0;
      it.string_index = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 63))
                                                    : IDX_W'($urandom_range(1, 6));
      it.zone         = ($urandom_range(0, 3) == 0) ? ZONE_W'($urandom_range(0, 63))
                                                    : ZONE_W'($urandom_range(0, 3));
      it.zone_mask    = {$urandom(), $urandom()};
      sel = $urandom_range(0, 99);
      if (sel < 42) begin
        it.op = OP_REGISTER;
      end else if (sel < 65) begin
        it.op = OP_UNREGISTER;
      end else if (sel < 97) begin
        it.op = OP_RELEASE;
        pick  = $urandom_range(0, 9);
        if (pick == 0) begin
          it.zone_mask = '0;
        end else if (pick == 1) begin
          it.zone_mask = 64'h1;
        end else if (pick >= 3) begin
          it.zone_mask = '0;
          it.zone_mask[$urandom_range(1, 3)] = 1'b1;
          if (pick >= 7) it.zone_mask[$urandom_range(0, 63)] = 1'b1;
        end
      end else begin
        it.op = OP_CLEAR;
      end
      pending_ops.push_back(it);
    end
    total_items = pending_ops.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction to go in and every result to come out.
    while (accepted_cnt < total_items || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Sender: bursts of random length with random gaps; hold the payload while
  // stalled, and predict each transaction at the edge where it is accepted.
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_results(in_data);
        accepted_cnt <= accepted_cnt + 1;
      end
      // Advance only when the port is free; a stalled payload stays put.
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_ops.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_data  <= pending_ops.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: stall density changes phase by phase, including phases with
  // no stall at all; once, hold off for a long stretch to back up the block.
  rx_mode_t rx_mode;
  int       phase_left;
  int       hold_left;
  logic     hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      rx_mode    = RX_FLOW;
      phase_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && accepted_cnt >= hold_at) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(16, 200);
      end else begin
        phase_left--;
      end
      case (rx_mode)
        RX_FLOW:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
        RX_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
        default:  out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  out_item_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0 && !out_stall) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result fv=%0b idx=%0d st=%0d any=%0b last=%0b",
                     out_data.freed_valid, out_data.freed_index, out_data.status,
                     out_data.any_owned, out_data.last));
      end else begin
        want = expected_results.pop_front();
        if (out_valid !== 1'b1 ||
            out_data.freed_valid !== want.freed_valid ||
            out_data.freed_index !== want.freed_index ||
            out_data.status      !== want.status      ||
            out_data.any_owned   !== want.any_owned   ||
            out_data.last        !== want.last) begin
          note_failure($sformatf({"mismatch: expected fv=%0b idx=%0d st=%0d any=%0b last=%0b,",
                       " got valid=%b fv=%b idx=%0d st=%0d any=%b last=%b"},
                       want.freed_valid, want.freed_index, want.status,
                       want.any_owned, want.last, out_valid,
                       out_data.freed_valid, out_data.freed_index, out_data.status,
                       out_data.any_owned, out_data.last));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
